>>> sv/bsm_pkg.sv
package bsm_pkg;

  localparam int WINDOW     = 20;
  localparam int SAMPLE_W   = 12;
  localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
  localparam int SUM_W      = $clog2(WINDOW * SAMPLE_MAX + 1);
  localparam int SUM_MAX    = WINDOW * SAMPLE_MAX;
  localparam int TIME_W     = 16;
  localparam int THR_W      = 12;
  localparam int TMO_W      = 8;
  localparam int SS_W       = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 12;

  // floor(sum / WINDOW) as (sum * AVG_MULT) >> AVG_SHIFT, exact over the sum range
  localparam int AVG_SHIFT  = SUM_W + $clog2(WINDOW);
  localparam int AVG_MULT   = ((1 << AVG_SHIFT) + WINDOW - 1) / WINDOW;
  localparam int MULT_W     = $clog2(AVG_MULT + 1);
  localparam int PROD_W     = SUM_W + MULT_W;

  localparam logic [SS_W-1:0] SS_MAX = '1;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = CFG_IDX_W'(1);

  localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(41);
  localparam logic [TMO_W-1:0] TIMEOUT_RESET   = TMO_W'(10);

  typedef struct packed {
    logic                kind;
    logic [SAMPLE_W-1:0] sample;
  } bsm_in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] average;
    logic [SAMPLE_W-1:0] min_seen;
    logic [SAMPLE_W-1:0] max_seen;
    logic [SS_W-1:0]     still_seconds;
    logic                alarm;
  } bsm_out_t;

  // state as seen right after one sample, handed to the snapshot stage
  typedef struct packed {
    logic [SUM_W-1:0]    sum;
    logic [SAMPLE_W-1:0] min_seen;
    logic [SAMPLE_W-1:0] max_seen;
    logic [SS_W-1:0]     still_seconds;
    logic                alarm;
  } bsm_snap_t;

endpackage

>>> sv/breath_stillness_monitor.sv
// Breath stillness monitor: takes one word per cycle while item_stall is low,
// either a 12-bit sensor sample or a one-second tick, and returns one result
// word per sample (none per tick) with the moving average over the last WINDOW
// samples, the min and max seen, the seconds the signal has been still and a
// sticky alarm. Samples shift through a row of WINDOW register cells whose last
// cell gives the sample leaving the running sum; the sum, marks and timers update
// in the cycle a word is accepted, so a new word is taken every cycle while
// item_stall is low. A result passes through a snapshot stage and an output
// stage that holds the divide-by-window multiplier; item_stall rises only while
// that output stage holds a word that has not been taken. Once the alarm is
// raised the state freezes until reset. Configuration (index 0 threshold, index
// 1 timeout) is always ready and should be written while the block is idle.
module breath_stillness_monitor
  import bsm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  bsm_in_t               item,
  output logic                  res_valid,
  input  logic                  res_stall,
  output bsm_out_t              res,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [THR_W-1:0]    still_threshold;
  logic [TMO_W-1:0]    timeout_seconds;

  logic [SUM_W-1:0]    window_sum;
  logic [SAMPLE_W-1:0] low_mark;
  logic [SAMPLE_W-1:0] high_mark;
  logic [TIME_W-1:0]   now_seconds;
  logic                still_valid;
  logic [TIME_W-1:0]   still_start;
  logic                ref_valid;
  logic [TIME_W-1:0]   ref_second;
  logic [SUM_W-1:0]    ref_sum;
  logic                alarm_flag;

  logic                advance;
  logic                item_acc;
  logic                sample_acc;
  logic                update;
  logic                tick_step;
  logic [SAMPLE_W-1:0] oldest;

  logic [SUM_W-1:0]    sum_next;
  logic [SAMPLE_W-1:0] low_next;
  logic [SAMPLE_W-1:0] high_next;
  logic [TIME_W-1:0]   start_eff;
  logic [TIME_W-1:0]   ref_second_eff;
  logic [SUM_W-1:0]    ref_sum_eff;
  logic [TIME_W-1:0]   still_elapsed;
  logic [TIME_W-1:0]   ref_elapsed;
  logic                alarm_set;
  logic                ref_close;
  logic [SUM_W-1:0]    diff;
  logic [SUM_W-1:0]    limit;
  logic                change;
  logic                still_valid_next;

  logic                snap_still_valid;
  logic [TIME_W-1:0]   snap_elapsed;
  bsm_snap_t           snap;

  assign cfg_ready  = 1'b1;
  assign item_stall = !advance;
  assign item_acc   = item_valid && !item_stall;
  assign sample_acc = item_acc && (item.kind == KIND_SAMPLE);
  assign update     = sample_acc && !alarm_flag;
  assign tick_step  = item_acc && (item.kind == KIND_TICK) && !alarm_flag;

  bsm_chain u_chain (
    .clk    (clk),
    .rst    (rst),
    .shift  (update),
    .din    (item.sample),
    .oldest (oldest)
  );

  always_comb begin
    sum_next  = window_sum - SUM_W'(oldest) + SUM_W'(item.sample);
    low_next  = (item.sample < low_mark) ? item.sample : low_mark;
    high_next = (item.sample > high_mark) ? item.sample : high_mark;

    // the timer and the reference start at the current second when not running
    start_eff      = still_valid ? still_start : now_seconds;
    ref_second_eff = ref_valid ? ref_second : now_seconds;
    ref_sum_eff    = ref_valid ? ref_sum : sum_next;

    still_elapsed = now_seconds - start_eff;
    ref_elapsed   = now_seconds - ref_second_eff;
    alarm_set     = still_elapsed >= TIME_W'(timeout_seconds);
    ref_close     = ref_elapsed != '0;

    diff   = (sum_next >= ref_sum) ? sum_next - ref_sum : ref_sum - sum_next;
    limit  = SUM_W'(still_threshold * WINDOW);
    change = diff > limit;

    still_valid_next = !(ref_close && change);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      still_threshold <= THRESHOLD_RESET;
      timeout_seconds <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_THRESHOLD) begin
        still_threshold <= THR_W'(cfg_data);
      end else if (cfg_index == REG_TIMEOUT) begin
        timeout_seconds <= TMO_W'(cfg_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum  <= '0;
      low_mark    <= SAMPLE_W'(SAMPLE_MAX);
      high_mark   <= '0;
      now_seconds <= '0;
      still_valid <= 1'b0;
      still_start <= '0;
      ref_valid   <= 1'b0;
      ref_second  <= '0;
      ref_sum     <= '0;
      alarm_flag  <= 1'b0;
    end else if (update) begin
      window_sum  <= sum_next;
      low_mark    <= low_next;
      high_mark   <= high_next;
      still_valid <= still_valid_next;
      still_start <= start_eff;
      ref_valid   <= !ref_close;
      ref_second  <= ref_second_eff;
      ref_sum     <= ref_sum_eff;
      alarm_flag  <= alarm_flag || alarm_set;
    end else if (tick_step) begin
      now_seconds <= now_seconds + TIME_W'(1);
    end
  end

  // result fields as the state stands after this sample
  always_comb begin
    snap_still_valid   = update ? still_valid_next : still_valid;
    snap_elapsed       = now_seconds - (update ? start_eff : still_start);
    snap.sum           = update ? sum_next : window_sum;
    snap.min_seen      = update ? low_next : low_mark;
    snap.max_seen      = update ? high_next : high_mark;
    snap.alarm         = alarm_flag || (update && alarm_set);
    if (!snap_still_valid) begin
      snap.still_seconds = '0;
    end else if (snap_elapsed > TIME_W'(SS_MAX)) begin
      snap.still_seconds = SS_MAX;
    end else begin
      snap.still_seconds = SS_W'(snap_elapsed);
    end
  end

  bsm_avg u_avg (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (sample_acc),
    .snap       (snap),
    .res_stall  (res_stall),
    .advance    (advance),
    .res_valid  (res_valid),
    .res        (res)
  );

  a_alarm_sticky: assert property (@(posedge clk) disable iff (rst)
    alarm_flag |=> alarm_flag)
    else $error("alarm dropped");

  a_frozen_sum: assert property (@(posedge clk) disable iff (rst)
    alarm_flag |=> $stable(window_sum) && $stable(now_seconds))
    else $error("state moved after alarm");

  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    window_sum <= SUM_W'(SUM_MAX))
    else $error("window sum out of range");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> res_valid && res_stall)
    else $error("input stalled with output free");

endmodule

>>> sv/bsm_cell.sv
module bsm_cell
  import bsm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                shift,
  input  logic [SAMPLE_W-1:0] d,
  output logic [SAMPLE_W-1:0] q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

>>> sv/bsm_chain.sv
module bsm_chain
  import bsm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                shift,
  input  logic [SAMPLE_W-1:0] din,
  output logic [SAMPLE_W-1:0] oldest
);

  logic [SAMPLE_W-1:0] tap [WINDOW+1];

  assign tap[0] = din;
  assign oldest = tap[WINDOW];

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    bsm_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .d     (tap[i]),
      .q     (tap[i+1])
    );
  end

endmodule

>>> sv/bsm_avg.sv
module bsm_avg
  import bsm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      snap_valid,
  input  bsm_snap_t snap,
  input  logic      res_stall,
  output logic      advance,
  output logic      res_valid,
  output bsm_out_t  res
);

  logic              s1_valid;
  bsm_snap_t         s1;
  logic [PROD_W-1:0] prod;

  assign advance = !res_valid || !res_stall;
  assign prod    = PROD_W'(s1.sum) * PROD_W'(AVG_MULT);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= snap_valid;
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1                <= snap;
      res.average       <= SAMPLE_W'(prod >> AVG_SHIFT);
      res.min_seen      <= s1.min_seen;
      res.max_seen      <= s1.max_seen;
      res.still_seconds <= s1.still_seconds;
      res.alarm         <= s1.alarm;
    end
  end

  // a word held in stage one must reach the output on the next move
  a_s1_moves: assert property (@(posedge clk) disable iff (rst)
    s1_valid && advance |=> res_valid)
    else $error("stage one word lost");

  // the average can never exceed the largest sample seen
  a_avg_bound: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.average <= res.max_seen)
    else $error("average above max");

endmodule
